/* rtl/wfs_pkg.sv */
// Shared constants and types for the wall-following PD steering block.
package wfs_pkg;

	// Default reading width in bits (unsigned, four fractional bits)
	localparam int DISTANCE_BITS_DEF = 14;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT   = 3'd4;

	// Register reset values
	localparam logic [11:0] P_GAIN_RST     = 12'd256;
	localparam logic [11:0] D_GAIN_RST     = 12'd0;
	localparam logic [11:0] BASE_SPEED_RST = 12'd96;
	localparam logic [11:0] MAX_SPEED_RST  = 12'd160;
	localparam logic [9:0]  SETPOINT_RST   = 10'd256;

	// Distance thresholds, in 1/16 units
	localparam int LEFT_CLAMP = 800;
	localparam int NEAR_LIMIT = 208;
	localparam int TURN_FL    = 288;
	localparam int TURN_FR    = 352;
	localparam int TURN_LEFT  = 608;
	localparam int KEEP_FL    = 528;
	localparam int KEEP_FR    = 704;
	localparam int KEEP_LEFT  = 576;
	localparam int FAR_LEFT   = 640;

	// Fixed turn velocities, in 1/16 units
	localparam logic signed [15:0] TURN_VEL_L = 16'sd80;
	localparam logic signed [15:0] TURN_VEL_R = -16'sd16;

	// Steering term width (clamped PD terms fit in 14 bits signed)
	localparam int TERM_W = 14;

	// Reciprocals for division by 5 and 6, scaled by 2^RECIP_SHIFT and rounded up
	localparam int RECIP_SHIFT = 16;
	localparam logic [TERM_W-1:0] RECIP5 = 14'd13108;
	localparam logic [TERM_W-1:0] RECIP6 = 14'd10923;

	// Drive mode codes as seen on the output
	typedef enum logic [2:0] {
		MODE_REVERSE  = 3'd0,
		MODE_TURNING  = 3'd1,
		MODE_TURN_END = 3'd2,
		MODE_FAR      = 3'd3,
		MODE_RECEDE   = 3'd4,
		MODE_NORMAL   = 3'd5
	} mode_t;

	// Correction divisor selection
	typedef enum logic [1:0] {
		SCALE_1 = 2'd0,
		SCALE_5 = 2'd1,
		SCALE_6 = 2'd2
	} scale_t;

endpackage

/* rtl/wfs_scale.sv */
// Signed steering term divided by 1, 5 or 6, truncating toward zero.
module wfs_scale (
	input  logic signed [wfs_pkg::TERM_W-1:0] term,
	input  wfs_pkg::scale_t                   sel,
	output logic signed [wfs_pkg::TERM_W-1:0] quot
);

	localparam int W = wfs_pkg::TERM_W;

	logic         neg;
	logic [W-1:0] mag;
	logic [2*W-1:0] prod5;
	logic [2*W-1:0] prod6;
	logic [W-1:0] q5;
	logic [W-1:0] q6;
	logic [W-1:0] qmag;

	// Work on the magnitude so that truncation goes toward zero
	assign neg = term[W-1];
	assign mag = neg ? W'(-term) : W'(term);

	// Multiply by the rounded-up reciprocal and drop the fraction
	assign prod5 = (2*W)'(mag) * (2*W)'(wfs_pkg::RECIP5);
	assign prod6 = (2*W)'(mag) * (2*W)'(wfs_pkg::RECIP6);
	assign q5 = W'(prod5 >> wfs_pkg::RECIP_SHIFT);
	assign q6 = W'(prod6 >> wfs_pkg::RECIP_SHIFT);

	// Pick the divisor and restore the sign
	always_comb begin
		unique case (sel)
			wfs_pkg::SCALE_5: qmag = q5;
			wfs_pkg::SCALE_6: qmag = q6;
			default:          qmag = mag;
		endcase
		quot = neg ? $signed(W'(-qmag)) : $signed(qmag);
	end

endmodule

/* rtl/wall_follow_pd_steering.sv */
// Top level of the wall-following PD steering block.
// Takes one set of three distance readings per transfer and returns one set of wheel
// velocities and a drive mode per transfer. The block accepts a new item in every cycle
// unless a stalled output has filled the pipeline, and each result passes through four
// registers on its way to the outputs: an input register, a register after the two gain
// multipliers, a register after rounding and clamping of the steering terms, and the
// output register after the divide-by-constant multipliers and the mode select. Bubbles
// collapse, so input transfers continue while a result is stalled until all four
// registers are full. The previous error and the turn flag are updated as an item leaves
// the input register; the held velocities are the contents of the output register, zero
// after reset.
module wall_follow_pd_steering #(
	parameter int DISTANCE_BITS = wfs_pkg::DISTANCE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [DISTANCE_BITS-1:0]          left_distance,
	input  logic [DISTANCE_BITS-1:0]          front_left_distance,
	input  logic [DISTANCE_BITS-1:0]          front_right_distance,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                left_velocity,
	output logic signed [15:0]                right_velocity,
	output logic [2:0]                        drive_mode
);

	// Compare width: holds four times a reading and every threshold
	localparam int CW = (DISTANCE_BITS + 2 > 11) ? DISTANCE_BITS + 2 : 11;
	localparam int TW = wfs_pkg::TERM_W;

	// Configuration registers
	logic [11:0] p_gain_q;
	logic [11:0] d_gain_q;
	logic [11:0] base_speed_q;
	logic [11:0] max_speed_q;
	logic [9:0]  setpoint_q;

	// Controller state
	logic signed [11:0] prev_error_q;
	logic               turn_q;

	// Pipeline registers
	logic                     valid_s1, valid_s2, valid_s3;
	logic [DISTANCE_BITS-1:0] left_s1, fl_s1, fr_s1;
	logic signed [24:0]       p_prod_s2, d_prod_s2;
	wfs_pkg::mode_t           mode_s2, mode_s3;
	logic signed [TW-1:0]     l_term_s3, r_term_s3;

	// Output register (also the held velocities)
	logic                 out_valid_q;
	logic signed [15:0]   lv_q, rv_q;
	wfs_pkg::mode_t       mode_q;

	// Flow control
	logic out_free, s3_free, s2_free, s1_free;

	// Stage 1 logic
	logic [CW-1:0]      left_ext, fl_ext, fr_ext;
	logic [9:0]         left_c;
	logic signed [11:0] perror, derror;
	logic               near, turn_start, turn_keep;
	wfs_pkg::mode_t     mode_d;
	logic               turn_d;

	// Stage 2 logic
	logic signed [25:0] pd_sum;
	logic signed [17:0] err, bs, b2, l_full, r_full;

	// Stage 3 logic
	wfs_pkg::scale_t      scale_sel;
	logic signed [TW-1:0] l_quot, r_quot;
	logic signed [15:0]   base16, lv_d, rv_d;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q     <= wfs_pkg::P_GAIN_RST;
			d_gain_q     <= wfs_pkg::D_GAIN_RST;
			base_speed_q <= wfs_pkg::BASE_SPEED_RST;
			max_speed_q  <= wfs_pkg::MAX_SPEED_RST;
			setpoint_q   <= wfs_pkg::SETPOINT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wfs_pkg::REG_P_GAIN:     p_gain_q     <= cfg_data;
				wfs_pkg::REG_D_GAIN:     d_gain_q     <= cfg_data;
				wfs_pkg::REG_BASE_SPEED: base_speed_q <= cfg_data;
				wfs_pkg::REG_MAX_SPEED:  max_speed_q  <= cfg_data;
				wfs_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when its slot is empty or its contents move on
	assign out_free = !out_valid_q || !out_stall;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)  valid_s1    <= in_valid;
			if (s2_free)  valid_s2    <= valid_s1;
			if (s3_free)  valid_s3    <= valid_s2;
			if (out_free) out_valid_q <= valid_s3;
		end
	end

	// Capture readings on an input transfer
	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			left_s1 <= left_distance;
			fl_s1   <= front_left_distance;
			fr_s1   <= front_right_distance;
		end
	end

	// Clamp the left reading and form the proportional and derivative errors
	assign left_ext = CW'(left_s1);
	assign fl_ext   = CW'(fl_s1);
	assign fr_ext   = CW'(fr_s1);
	assign left_c   = (left_ext > CW'(wfs_pkg::LEFT_CLAMP)) ?
		10'(wfs_pkg::LEFT_CLAMP) : left_ext[9:0];
	assign perror   = $signed({2'b00, left_c}) - $signed({2'b00, setpoint_q});
	assign derror   = perror - prev_error_q;

	// Obstacle and turn conditions
	assign near = (fl_ext < CW'(wfs_pkg::NEAR_LIMIT)) || (fr_ext < CW'(wfs_pkg::NEAR_LIMIT));
	assign turn_start = (fl_ext < CW'(wfs_pkg::TURN_FL))
		&& ((fr_ext < CW'(wfs_pkg::TURN_FR)) || (fr_ext > (fl_ext << 2)))
		&& (left_ext < CW'(wfs_pkg::TURN_LEFT));
	assign turn_keep = (fl_ext < CW'(wfs_pkg::KEEP_FL))
		&& ((fr_ext < CW'(wfs_pkg::KEEP_FR)) || (fr_ext > (fl_ext << 1)))
		&& (left_ext < CW'(wfs_pkg::KEEP_LEFT));

	// Decide the drive mode and the next turn flag
	always_comb begin
		turn_d = turn_q;
		if (near) begin
			mode_d = wfs_pkg::MODE_REVERSE;
		end else if (turn_start || turn_q) begin
			if (turn_keep) begin
				mode_d = wfs_pkg::MODE_TURNING;
				turn_d = 1'b1;
			end else begin
				mode_d = wfs_pkg::MODE_TURN_END;
				turn_d = 1'b0;
			end
		end else if ((derror == 12'sd0) && (left_ext > CW'(wfs_pkg::FAR_LEFT))) begin
			mode_d = wfs_pkg::MODE_FAR;
		end else if (derror > 12'sd0) begin
			mode_d = wfs_pkg::MODE_RECEDE;
		end else begin
			mode_d = wfs_pkg::MODE_NORMAL;
		end
	end

	// Update controller state as an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			turn_q       <= 1'b0;
		end else if (s2_free && valid_s1) begin
			prev_error_q <= perror;
			turn_q       <= turn_d;
		end
	end

	// Multiply by the gains
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			p_prod_s2 <= 25'($signed({1'b0, p_gain_q})) * 25'(perror);
			d_prod_s2 <= 25'($signed({1'b0, d_gain_q})) * 25'(derror);
			mode_s2   <= mode_d;
		end
	end

	// Round the Q8 sum half up and clamp it into the two steering terms
	assign pd_sum = {p_prod_s2[24], p_prod_s2} - {d_prod_s2[24], d_prod_s2} + 26'sd128;
	assign err    = pd_sum[25:8];
	assign bs     = $signed({6'd0, base_speed_q});
	assign b2     = $signed({5'd0, base_speed_q, 1'b0});

	always_comb begin
		l_full = err;
		r_full = err;
		if (err > b2) l_full = b2;
		if (err > bs) r_full = bs;
		if (err < -bs) l_full = -bs;
		if (err < -b2) r_full = -b2;
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			l_term_s3 <= l_full[TW-1:0];
			r_term_s3 <= r_full[TW-1:0];
			mode_s3   <= mode_s2;
		end
	end

	// Scale the corrections for the gentle modes
	always_comb begin
		case (mode_s3)
			wfs_pkg::MODE_FAR:    scale_sel = wfs_pkg::SCALE_5;
			wfs_pkg::MODE_RECEDE: scale_sel = wfs_pkg::SCALE_6;
			default:              scale_sel = wfs_pkg::SCALE_1;
		endcase
	end

	wfs_scale u_scale_l (
		.term (l_term_s3),
		.sel  (scale_sel),
		.quot (l_quot)
	);

	wfs_scale u_scale_r (
		.term (r_term_s3),
		.sel  (scale_sel),
		.quot (r_quot)
	);

	// Select the wheel velocities for the mode
	assign base16 = $signed({4'd0, base_speed_q});

	always_comb begin
		case (mode_s3)
			wfs_pkg::MODE_REVERSE: begin
				lv_d = -$signed({4'd0, max_speed_q});
				rv_d = lv_d;
			end
			wfs_pkg::MODE_TURNING: begin
				lv_d = wfs_pkg::TURN_VEL_L;
				rv_d = wfs_pkg::TURN_VEL_R;
			end
			wfs_pkg::MODE_TURN_END: begin
				lv_d = lv_q;
				rv_d = rv_q;
			end
			default: begin
				lv_d = base16 - {{(16-TW){l_quot[TW-1]}}, l_quot};
				rv_d = base16 + {{(16-TW){r_quot[TW-1]}}, r_quot};
			end
		endcase
	end

	// Load the result; it also serves as the held velocities
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q   <= '0;
			rv_q   <= '0;
			mode_q <= wfs_pkg::MODE_REVERSE;
		end else if (out_free && valid_s3) begin
			lv_q   <= lv_d;
			rv_q   <= rv_d;
			mode_q <= mode_s3;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_velocity  = lv_q;
	assign right_velocity = rv_q;
	assign drive_mode     = mode_q;

	// A turn starts only with an item that took the turning mode
	a_turn_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(turn_q) |-> valid_s2 && (mode_s2 == wfs_pkg::MODE_TURNING))
		else $error("turn flag set without a turning item");

	// A turn ends only with an item that took the turn-end mode
	a_turn_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(turn_q) |-> valid_s2 && (mode_s2 == wfs_pkg::MODE_TURN_END))
		else $error("turn flag cleared without a turn-end item");

	// Reverse drives both wheels alike
	a_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (drive_mode == wfs_pkg::MODE_REVERSE) |-> left_velocity == right_velocity)
		else $error("reverse result with unequal wheel velocities");

	// A turn-end result repeats the previous result's velocities
	a_turn_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_free && valid_s3 && (mode_s3 == wfs_pkg::MODE_TURN_END)
		|=> $stable(left_velocity) && $stable(right_velocity))
		else $error("turn-end result changed the held velocities");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the wall-following PD steering block.
localparam int DW  = wfs_pkg::DISTANCE_BITS_DEF;
localparam int CDW = wfs_pkg::CFG_DATA_W;

typedef struct {
	logic signed [15:0] left_vel;
	logic signed [15:0] right_vel;
	wfs_pkg::mode_t     mode;
} wheel_cmd_t;

// Steering predictor and queue of expected wheel commands
class steering_scoreboard;
	logic [11:0]        kp;
	logic [11:0]        kd;
	logic [11:0]        base;
	logic [11:0]        vmax;
	logic [9:0]         setpoint;
	logic signed [11:0] last_error;
	bit                 turning;
	logic signed [15:0] held_left;
	logic signed [15:0] held_right;
	wheel_cmd_t         cmd_queue[$];
	int                 failures;

	function new();
		kp         = wfs_pkg::P_GAIN_RST;
		kd         = wfs_pkg::D_GAIN_RST;
		base       = wfs_pkg::BASE_SPEED_RST;
		vmax       = wfs_pkg::MAX_SPEED_RST;
		setpoint   = wfs_pkg::SETPOINT_RST;
		last_error = '0;
		turning    = 1'b0;
		held_left  = '0;
		held_right = '0;
		failures   = 0;
	endfunction

	function void set_register(logic [wfs_pkg::CFG_INDEX_W-1:0] idx,
			logic [wfs_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			wfs_pkg::REG_P_GAIN:     kp = value;
			wfs_pkg::REG_D_GAIN:     kd = value;
			wfs_pkg::REG_BASE_SPEED: base = value;
			wfs_pkg::REG_MAX_SPEED:  vmax = value;
			wfs_pkg::REG_SETPOINT:   setpoint = value[9:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return cmd_queue.size();
	endfunction

	// Work out the wheel command for one accepted set of readings
	function void note_input(logic [DW-1:0] l_in, logic [DW-1:0] fl_in,
			logic [DW-1:0] fr_in);
		longint left, fl, fr, b, perr, derr, prod, err, lt, rt, lv, rv;
		wheel_cmd_t cmd;
		left = longint'(l_in);
		fl   = longint'(fl_in);
		fr   = longint'(fr_in);
		b    = longint'(base);
		if (left > wfs_pkg::LEFT_CLAMP) left = longint'(wfs_pkg::LEFT_CLAMP);
		perr = left - longint'(setpoint);
		derr = perr - longint'(last_error);
		last_error = perr[11:0];
		// round half up: floor of (x + 128) / 256
		prod = longint'(kp) * perr - longint'(kd) * derr;
		err  = (prod + 128) >>> 8;
		lt = err;
		rt = err;
		if (err > 2 * b) lt = 2 * b;
		if (err > b) rt = b;
		if (err < -b) lt = -b;
		if (err < -2 * b) rt = -2 * b;
		if (fl < wfs_pkg::NEAR_LIMIT || fr < wfs_pkg::NEAR_LIMIT) begin
			lv = -longint'(vmax);
			rv = lv;
			cmd.mode = wfs_pkg::MODE_REVERSE;
		end else if ((fl < wfs_pkg::TURN_FL && (fr < wfs_pkg::TURN_FR || fr > 4 * fl)
				&& left < wfs_pkg::TURN_LEFT) || turning) begin
			if (fl < wfs_pkg::KEEP_FL && (fr < wfs_pkg::KEEP_FR || fr > 2 * fl)
					&& left < wfs_pkg::KEEP_LEFT) begin
				turning = 1'b1;
				lv = longint'(wfs_pkg::TURN_VEL_L);
				rv = longint'(wfs_pkg::TURN_VEL_R);
				cmd.mode = wfs_pkg::MODE_TURNING;
			end else begin
				turning = 1'b0;
				lv = longint'(held_left);
				rv = longint'(held_right);
				cmd.mode = wfs_pkg::MODE_TURN_END;
			end
		end else if (derr == 0 && left > wfs_pkg::FAR_LEFT) begin
			lv = b - lt / 5;
			rv = b + rt / 5;
			cmd.mode = wfs_pkg::MODE_FAR;
		end else if (derr > 0) begin
			lv = b - lt / 6;
			rv = b + rt / 6;
			cmd.mode = wfs_pkg::MODE_RECEDE;
		end else begin
			lv = b - lt;
			rv = b + rt;
			cmd.mode = wfs_pkg::MODE_NORMAL;
		end
		held_left  = lv[15:0];
		held_right = rv[15:0];
		cmd.left_vel  = lv[15:0];
		cmd.right_vel = rv[15:0];
		cmd_queue.push_back(cmd);
	endfunction

	// Compare one output transfer with the oldest expected command
	function void check_result(logic signed [15:0] lv, logic signed [15:0] rv,
			logic [2:0] mode);
		wheel_cmd_t cmd;
		if (cmd_queue.size() == 0) begin
			$error("unexpected result: left_velocity %0d right_velocity %0d drive_mode %0d",
				lv, rv, mode);
			failures++;
			return;
		end
		cmd = cmd_queue.pop_front();
		if (lv !== cmd.left_vel) begin
			$error("left_velocity: expected %0d, actual %0d", cmd.left_vel, lv);
			failures++;
		end
		if (rv !== cmd.right_vel) begin
			$error("right_velocity: expected %0d, actual %0d", cmd.right_vel, rv);
			failures++;
		end
		if (mode !== cmd.mode) begin
			$error("drive_mode: expected %0d, actual %0d", cmd.mode, mode);
			failures++;
		end
	endfunction
endclass

module testbench;
	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [wfs_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [wfs_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [DW-1:0]                   left_distance;
	logic [DW-1:0]                   front_left_distance;
	logic [DW-1:0]                   front_right_distance;
	logic                            out_valid;
	logic                            out_stall;
	logic signed [15:0]              left_velocity;
	logic signed [15:0]              right_velocity;
	logic [2:0]                      drive_mode;

	steering_scoreboard steering_sb;
	int send_idle;
	int recv_idle;

	wall_follow_pd_steering #(.DISTANCE_BITS(DW)) DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.left_distance        (left_distance),
		.front_left_distance  (front_left_distance),
		.front_right_distance (front_right_distance),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.left_velocity        (left_velocity),
		.right_velocity       (right_velocity),
		.drive_mode           (drive_mode)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

	// Randomly stall the output side
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			steering_sb.check_result(left_velocity, right_velocity, drive_mode);
	end

	// Drive one register write; the caller drops the write enable
	task automatic write_reg(logic [wfs_pkg::CFG_INDEX_W-1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CDW'(value);
		@(negedge clk);
		steering_sb.set_register(idx, CDW'(value));
	endtask

	task automatic program_regs(int kp, int kd, int base, int vmax, int sp);
		write_reg(wfs_pkg::REG_P_GAIN, kp);
		write_reg(wfs_pkg::REG_D_GAIN, kd);
		write_reg(wfs_pkg::REG_BASE_SPEED, base);
		write_reg(wfs_pkg::REG_MAX_SPEED, vmax);
		write_reg(wfs_pkg::REG_SETPOINT, sp);
		cfg_we <= 1'b0;
	endtask

	// Offer one set of readings, holding it until the transfer
	task automatic send_reading(int l, int fl, int fr);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid             <= 1'b1;
		left_distance        <= DW'(l);
		front_left_distance  <= DW'(fl);
		front_right_distance <= DW'(fr);
		do @(posedge clk); while (in_stall);
		steering_sb.note_input(DW'(l), DW'(fl), DW'(fr));
		@(negedge clk);
	endtask

	// Wait until every expected command has come out and the pipeline has emptied
	task automatic wait_drained();
		while (steering_sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int near_threshold();
		int marks[9];
		marks = '{wfs_pkg::NEAR_LIMIT, wfs_pkg::TURN_FL, wfs_pkg::TURN_FR,
			wfs_pkg::TURN_LEFT, wfs_pkg::KEEP_FL, wfs_pkg::KEEP_FR, wfs_pkg::KEEP_LEFT,
			wfs_pkg::FAR_LEFT, wfs_pkg::LEFT_CLAMP};
		return marks[$urandom_range(8)] - 2 + $urandom_range(4);
	endfunction

	// Send one short driving sequence; count the transfers it makes
	task automatic send_sequence(inout int sent);
		int kind, n, l, fl, fr, i;
		kind = $urandom_range(99);
		if (kind < 12) begin
			// noise over the whole reading range
			send_reading($urandom_range(16383), $urandom_range(16383), $urandom_range(16383));
			sent++;
		end else if (kind < 45) begin
			// cruise along the wall, sometimes holding the left reading steady
			n = $urandom_range(1, 6);
			l = $urandom_range(0, 1000);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(2) == 0) l = $urandom_range(0, 1000);
				send_reading(l, $urandom_range(wfs_pkg::KEEP_FR, 16383),
					$urandom_range(wfs_pkg::KEEP_FR, 16383));
				sent++;
			end
		end else if (kind < 80) begin
			// corner: enter the turn, stay in it, then leave it
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++) begin
				fl = $urandom_range(wfs_pkg::NEAR_LIMIT, wfs_pkg::TURN_FL - 1);
				fr = ($urandom_range(1) == 0)
					? $urandom_range(wfs_pkg::NEAR_LIMIT, wfs_pkg::TURN_FR - 1)
					: $urandom_range(4 * fl + 1, 16383);
				send_reading($urandom_range(0, wfs_pkg::TURN_LEFT - 1), fl, fr);
				sent++;
			end
			n = $urandom_range(0, 4);
			for (i = 0; i < n; i++) begin
				fl = $urandom_range(wfs_pkg::NEAR_LIMIT, wfs_pkg::KEEP_FL - 1);
				fr = ($urandom_range(1) == 0)
					? $urandom_range(wfs_pkg::NEAR_LIMIT, wfs_pkg::KEEP_FR - 1)
					: $urandom_range(2 * fl + 1, 16383);
				if ($urandom_range(7) == 0) fr = $urandom_range(0, wfs_pkg::NEAR_LIMIT - 1);
				send_reading($urandom_range(0, wfs_pkg::KEEP_LEFT - 1), fl, fr);
				sent++;
			end
			send_reading($urandom_range(0, 1200), $urandom_range(wfs_pkg::NEAR_LIMIT, 2000),
				$urandom_range(wfs_pkg::NEAR_LIMIT, 16383));
			sent++;
		end else if (kind < 88) begin
			// obstacle ahead
			fl = $urandom_range(0, 16383);
			fr = $urandom_range(0, wfs_pkg::NEAR_LIMIT - 1);
			if ($urandom_range(1) == 0) begin
				fr = fl;
				fl = $urandom_range(0, wfs_pkg::NEAR_LIMIT - 1);
			end
			send_reading($urandom_range(0, 16383), fl, fr);
			sent++;
		end else begin
			// readings on the edges of the thresholds
			send_reading(near_threshold(), near_threshold(), near_threshold());
			sent++;
		end
	endtask

	task automatic send_directed();
		send_reading(0, 0, 0);
		send_reading(16383, 16383, 16383);
		send_reading(16383, 16383, 16383);
		send_reading(0, 16383, 16383);
		send_reading(300, 16383, 207);
		send_reading(300, 207, 16383);
		send_reading(400, 250, 300);
		send_reading(400, 500, 16383);
		send_reading(400, 600, 16383);
		send_reading(400, 250, 1200);
		send_reading(400, 100, 16383);
		send_reading(400, 300, 500);
		send_reading(700, 16383, 16383);
		send_reading(256, 16383, 16383);
		send_reading(256, 16383, 16383);
		send_reading(641, 1000, 1000);
		send_reading(641, 1000, 1000);
		send_reading(600, 287, 351);
		send_reading(607, 288, 351);
		send_reading(500, 288, 352);
		send_reading(500, 208, 208);
		send_reading(16383, 0, 16383);
		send_reading(5461, 10922, 5461);
	endtask

	initial begin
		int phase, sent;
		steering_sb          = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_valid             = 1'b0;
		left_distance        = '0;
		front_left_distance  = '0;
		front_right_distance = '0;
		send_idle            = 0;
		recv_idle            = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				in_valid <= 1'b0;
				wait_drained();
				case (phase)
					2: program_regs(0, 0, 0, 0, 0);
					3: program_regs(4095, 4095, 4095, 4095, 800);
					5: program_regs($urandom_range(64, 1024), $urandom_range(0, 512),
						$urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 800));
					default: program_regs($urandom_range(4095), $urandom_range(4095),
						$urandom_range(4095), $urandom_range(4095), $urandom_range(800));
				endcase
			end
			// receiver lazy first, then sender lazy, then neither
			if (phase < 2) begin
				send_idle = 13;
				recv_idle = 78;
			end else if (phase < 4) begin
				send_idle = 78;
				recv_idle = 13;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (phase == 0) send_directed();
			sent = 0;
			while (sent < 280) send_sequence(sent);
		end

		in_valid <= 1'b0;
		wait_drained();
		if (steering_sb.failures == 0 && steering_sb.pending() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
